// ----- hw/rtl/crc8cfr_pkg.sv -----
// Shared types, constants and functions of the CRC-8 checked frame receiver.
package crc8cfr_pkg;

  localparam int unsigned MaxFrameLength = 32;

  localparam int unsigned PosW    = 5;
  localparam int unsigned ByteW   = 8;
  localparam int unsigned CfgIdxW = 1;

  localparam logic [PosW-1:0] MinLen = PosW'(3);
  localparam logic [PosW-1:0] TopLen =
    (MaxFrameLength < 31) ? PosW'(MaxFrameLength) : PosW'(31);

  localparam logic [PosW-1:0] IdentLenRst = PosW'(6);
  localparam logic [PosW-1:0] DataLenRst  = PosW'(25);

  localparam logic [ByteW-1:0] StartByte = 8'h52;
  localparam logic [ByteW-1:0] TypeIdent = 8'h69;
  localparam logic [ByteW-1:0] TypeData  = 8'h64;
  localparam logic [ByteW-1:0] CrcPoly   = 8'h8C;

  typedef enum logic [2:0] {
    ST_PROGRESS  = 3'd0,
    ST_GOOD      = 3'd1,
    ST_BAD_START = 3'd2,
    ST_BAD_TYPE  = 3'd3,
    ST_BAD_CRC   = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    KIND_NONE  = 2'd0,
    KIND_IDENT = 2'd1,
    KIND_DATA  = 2'd2
  } kind_t;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_IDENT_LEN = 1'b0,
    CFG_DATA_LEN  = 1'b1
  } cfg_idx_t;

  typedef struct packed {
    status_t          status;
    kind_t            kind;
    logic [PosW-1:0]  pos;
    logic [ByteW-1:0] data;
    logic             frame_end;
  } result_t;

  function automatic logic [ByteW-1:0] crc8_step(input logic [ByteW-1:0] crc,
                                                 input logic [ByteW-1:0] b);
    logic [ByteW-1:0] c;
    c = crc ^ b;
    for (int i = 0; i < ByteW; i++) begin
      c = c[0] ? ((c >> 1) ^ CrcPoly) : (c >> 1);
    end
    return c;
  endfunction

  function automatic logic [PosW-1:0] clamp_len(input logic [PosW-1:0] len);
    logic [PosW-1:0] l;
    l = (len < MinLen) ? MinLen : len;
    l = (l > TopLen) ? TopLen : l;
    return l;
  endfunction

endpackage

// ----- hw/rtl/crc8cfr_parser.sv -----
// Frame delimiting state, length registers and CRC check for one byte per cycle while accept is high.
module crc8cfr_parser (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           accept,
  input  logic [crc8cfr_pkg::ByteW-1:0]  rx_byte,
  input  logic                           cfg_we,
  input  logic [crc8cfr_pkg::CfgIdxW-1:0] cfg_index,
  input  logic [crc8cfr_pkg::PosW-1:0]   cfg_wdata,
  output crc8cfr_pkg::result_t           result
);
  import crc8cfr_pkg::*;

  logic [PosW-1:0]  ident_len_r, data_len_r;
  logic [PosW-1:0]  count_r, count_nxt;
  logic             start_ok_r, start_ok_nxt;
  kind_t            kind_r, kind_nxt;
  logic [PosW-1:0]  exp_len_r, exp_len_nxt;
  logic [ByteW-1:0] crc_r, crc_nxt;
  logic [PosW:0]    pos_inc;

  assign pos_inc = {1'b0, count_r} + (PosW+1)'(1);

  always_comb begin
    result.status    = ST_PROGRESS;
    result.kind      = KIND_NONE;
    result.pos       = count_r;
    result.data      = rx_byte;
    result.frame_end = 1'b0;
    count_nxt    = count_r;
    start_ok_nxt = start_ok_r;
    kind_nxt     = kind_r;
    exp_len_nxt  = exp_len_r;
    crc_nxt      = crc_r;
    if (count_r == PosW'(0)) begin
      start_ok_nxt = (rx_byte == StartByte);
      count_nxt    = PosW'(1);
    end else if (count_r == PosW'(1)) begin
      if (!start_ok_r) begin
        result.status    = ST_BAD_START;
        result.frame_end = 1'b1;
      end else if (rx_byte == TypeIdent || rx_byte == TypeData) begin
        kind_nxt    = (rx_byte == TypeIdent) ? KIND_IDENT : KIND_DATA;
        exp_len_nxt = clamp_len((rx_byte == TypeIdent) ? ident_len_r : data_len_r);
        crc_nxt     = crc8_step('0, rx_byte);
        result.kind = kind_nxt;
        count_nxt   = PosW'(2);
      end else begin
        result.status    = ST_BAD_TYPE;
        result.frame_end = 1'b1;
      end
    end else begin
      result.kind = kind_r;
      if (pos_inc >= {1'b0, exp_len_r}) begin
        result.status    = (crc_r == rx_byte) ? ST_GOOD : ST_BAD_CRC;
        result.frame_end = 1'b1;
      end else begin
        crc_nxt   = crc8_step(crc_r, rx_byte);
        count_nxt = pos_inc[PosW-1:0];
      end
    end
    if (result.frame_end) begin
      count_nxt    = '0;
      start_ok_nxt = 1'b0;
      kind_nxt     = KIND_NONE;
      exp_len_nxt  = '0;
      crc_nxt      = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ident_len_r <= IdentLenRst;
      data_len_r  <= DataLenRst;
      count_r     <= '0;
      start_ok_r  <= 1'b0;
      kind_r      <= KIND_NONE;
      exp_len_r   <= '0;
      crc_r       <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_idx_t'(cfg_index))
          CFG_IDENT_LEN: ident_len_r <= cfg_wdata;
          CFG_DATA_LEN:  data_len_r  <= cfg_wdata;
          default: ;
        endcase
      end
      if (accept) begin
        count_r    <= count_nxt;
        start_ok_r <= start_ok_nxt;
        kind_r     <= kind_nxt;
        exp_len_r  <= exp_len_nxt;
        crc_r      <= crc_nxt;
      end
    end
  end

endmodule

// ----- hw/rtl/crc8cfr_out_buf.sv -----
// Two-entry result register with skid slot between the parser and the output channel.
module crc8cfr_out_buf (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  crc8cfr_pkg::result_t push_data,
  output logic                 full,
  output logic                 out_valid,
  input  logic                 out_stall,
  output crc8cfr_pkg::result_t out_data
);
  import crc8cfr_pkg::*;

  logic    main_valid_r, main_valid_nxt;
  logic    skid_valid_r, skid_valid_nxt;
  result_t main_r, main_nxt;
  result_t skid_r, skid_nxt;
  logic    take;

  assign take      = main_valid_r && !out_stall;
  assign full      = skid_valid_r;
  assign out_valid = main_valid_r;
  assign out_data  = main_r;

  always_comb begin
    main_valid_nxt = main_valid_r;
    skid_valid_nxt = skid_valid_r;
    main_nxt       = main_r;
    skid_nxt       = skid_r;
    if (take) begin
      if (skid_valid_r) begin
        main_nxt       = skid_r;
        skid_valid_nxt = 1'b0;
      end else if (push) begin
        main_nxt = push_data;
      end else begin
        main_valid_nxt = 1'b0;
      end
    end else if (push) begin
      if (!main_valid_r) begin
        main_nxt       = push_data;
        main_valid_nxt = 1'b1;
      end else begin
        skid_nxt       = push_data;
        skid_valid_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_valid_r <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      main_valid_r <= main_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
    main_r <= main_nxt;
    skid_r <= skid_nxt;
  end

endmodule

// ----- hw/rtl/crc8_checked_frame_receiver.sv -----
// Top level of the CRC-8 checked reply-frame receiver.
// One received byte per transaction, one result per byte. A byte is checked and
// its result registered in the cycle it is accepted, so a byte can be taken on every
// clock; results leave the output register in the order taken. A two-entry output
// register lets one more byte in while a result waits; the input stalls only when both
// entries hold results. Frames start with 'R', then 'i' (ident) or 'd' (data); the
// last byte is a reflected CRC-8 (poly 0x8C, init 0) over the type and payload bytes.
// Lengths are set through cfg index 0 (ident) and 1 (data); write them only when idle.
module crc8_checked_frame_receiver (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [crc8cfr_pkg::ByteW-1:0]   in_rx_byte,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [2:0]                      out_frame_status,
  output logic [1:0]                      out_frame_kind,
  output logic [crc8cfr_pkg::PosW-1:0]    out_byte_position,
  output logic [crc8cfr_pkg::ByteW-1:0]   out_echo_byte,
  output logic                            out_frame_end,
  input  logic                            cfg_we,
  input  logic [crc8cfr_pkg::CfgIdxW-1:0] cfg_index,
  input  logic [crc8cfr_pkg::PosW-1:0]    cfg_wdata
);
  import crc8cfr_pkg::*;

  logic    accept;
  logic    buf_full;
  result_t parse_res;
  result_t out_res;

  assign in_stall = buf_full;
  assign accept   = in_valid && !buf_full;

  crc8cfr_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .rx_byte   (in_rx_byte),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .result    (parse_res)
  );

  crc8cfr_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (accept),
    .push_data (parse_res),
    .full      (buf_full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_res)
  );

  assign out_frame_status  = out_res.status;
  assign out_frame_kind    = out_res.kind;
  assign out_byte_position = out_res.pos;
  assign out_echo_byte     = out_res.data;
  assign out_frame_end     = out_res.frame_end;

`ifndef SYNTHESIS
  a_stall_needs_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid)
    else $error("input stalled with no result held");

  a_end_has_status: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_frame_end) |-> (out_frame_status != ST_PROGRESS))
    else $error("frame end reported while in progress");

  a_kind_known_late: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_byte_position > 5'd1) |-> (out_frame_kind != KIND_NONE))
    else $error("byte past type position without a frame kind");

  a_restart_after_end: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && parse_res.frame_end) |=> (parse_res.pos == '0))
    else $error("position not cleared after frame end");
`endif

endmodule

// ----- bench/crc8_checked_frame_receiver_check.sv -----
// CRC-8 helpers and the result checker of the frame receiver test.
package crc8cfr_tb_pkg;

  import crc8cfr_pkg::*;

  // Reflected Dallas/Maxim CRC-8, fed one data bit at a time from the LSB.
  function automatic logic [ByteW-1:0] crc8_maxim(input logic [ByteW-1:0] crc,
                                                  input logic [ByteW-1:0] b);
    logic [ByteW-1:0] acc;
    logic             mix;
    acc = crc;
    for (int i = 0; i < ByteW; i++) begin
      mix = acc[0] ^ b[i];
      acc = acc >> 1;
      if (mix) begin
        acc = acc ^ CrcPoly;
      end
    end
    return acc;
  endfunction

  function automatic logic [PosW-1:0] fit_length(input logic [PosW-1:0] len);
    if (len < MinLen) begin
      return MinLen;
    end
    if (len > TopLen) begin
      return TopLen;
    end
    return len;
  endfunction

endpackage

module crc8_checked_frame_receiver_check (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  input  logic                            in_stall,
  input  logic [crc8cfr_pkg::ByteW-1:0]   in_rx_byte,
  input  logic                            out_valid,
  input  logic                            out_stall,
  input  logic [2:0]                      out_frame_status,
  input  logic [1:0]                      out_frame_kind,
  input  logic [crc8cfr_pkg::PosW-1:0]    out_byte_position,
  input  logic [crc8cfr_pkg::ByteW-1:0]   out_echo_byte,
  input  logic                            out_frame_end,
  input  logic                            cfg_we,
  input  logic [crc8cfr_pkg::CfgIdxW-1:0] cfg_index,
  input  logic [crc8cfr_pkg::PosW-1:0]    cfg_wdata,
  output int                              fail_count,
  output int                              outstanding
);

  timeunit 1ns;
  timeprecision 1ps;

  import crc8cfr_pkg::*;
  import crc8cfr_tb_pkg::*;

  logic [PosW-1:0]  ident_len;
  logic [PosW-1:0]  data_len;
  logic [PosW-1:0]  next_pos;
  logic             saw_start;
  kind_t            latched_kind;
  logic [PosW-1:0]  latched_len;
  logic [ByteW-1:0] frame_crc;
  result_t          awaited_echoes[$];
  int               error_total = 0;

  function automatic void clear_frame();
    next_pos     = '0;
    saw_start    = 1'b0;
    latched_kind = KIND_NONE;
    latched_len  = '0;
    frame_crc    = '0;
  endfunction

  function automatic result_t receive_byte(input logic [ByteW-1:0] b);
    result_t r;
    r.status    = ST_PROGRESS;
    r.kind      = KIND_NONE;
    r.pos       = next_pos;
    r.data      = b;
    r.frame_end = 1'b0;
    if (next_pos == PosW'(0)) begin
      saw_start = (b == StartByte);
      next_pos  = PosW'(1);
    end else if (next_pos == PosW'(1)) begin
      if (!saw_start) begin
        r.status    = ST_BAD_START;
        r.frame_end = 1'b1;
        clear_frame();
      end else if (b == TypeIdent || b == TypeData) begin
        latched_kind = (b == TypeIdent) ? KIND_IDENT : KIND_DATA;
        latched_len  = fit_length((b == TypeIdent) ? ident_len : data_len);
        frame_crc    = crc8_maxim(8'h00, b);
        r.kind       = latched_kind;
        next_pos     = PosW'(2);
      end else begin
        r.status    = ST_BAD_TYPE;
        r.frame_end = 1'b1;
        clear_frame();
      end
    end else begin
      r.kind = latched_kind;
      if (int'(next_pos) + 1 >= int'(latched_len)) begin
        r.status    = (frame_crc == b) ? ST_GOOD : ST_BAD_CRC;
        r.frame_end = 1'b1;
        clear_frame();
      end else begin
        frame_crc = crc8_maxim(frame_crc, b);
        next_pos  = next_pos + PosW'(1);
      end
    end
    return r;
  endfunction

  function automatic int field_diff(input string name, input logic [7:0] want,
                                    input logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      return 1;
    end
    return 0;
  endfunction

  always @(posedge clk) begin
    result_t want;
    int      bad;
    if (!rst_n) begin
      ident_len = IdentLenRst;
      data_len  = DataLenRst;
      clear_frame();
      awaited_echoes.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_IDENT_LEN: ident_len = cfg_wdata;
          CFG_DATA_LEN:  data_len  = cfg_wdata;
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        if (awaited_echoes.size() == 0) begin
          $error("result with no transaction pending: position %0d, byte %0d",
                 out_byte_position, out_echo_byte);
          error_total++;
        end else begin
          want = awaited_echoes.pop_front();
          bad  = 0;
          bad += field_diff("frame_status", 8'(want.status), 8'(out_frame_status));
          bad += field_diff("frame_kind", 8'(want.kind), 8'(out_frame_kind));
          bad += field_diff("byte_position", 8'(want.pos), 8'(out_byte_position));
          bad += field_diff("echo_byte", want.data, out_echo_byte);
          bad += field_diff("frame_end", 8'(want.frame_end), 8'(out_frame_end));
          if (bad != 0) begin
            error_total++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        awaited_echoes.push_back(receive_byte(in_rx_byte));
      end
    end
    fail_count  <= error_total;
    outstanding <= awaited_echoes.size();
  end

endmodule

// ----- bench/crc8_checked_frame_receiver_test.sv -----
// Stimulus, reset, clock and verdict for the CRC-8 checked frame receiver.
module crc8_checked_frame_receiver_test;

  timeunit 1ns;
  timeprecision 1ps;

  import crc8cfr_pkg::*;
  import crc8cfr_tb_pkg::*;

  localparam int QuietLimit  = 5000;
  localparam int PhaseBytes  = 46;
  localparam int PhaseCount  = 8;

  logic                clk;
  logic                rst_n       = 1'b0;
  logic                in_valid    = 1'b0;
  logic                in_stall;
  logic [ByteW-1:0]    in_rx_byte  = '0;
  logic                out_valid;
  logic                out_stall   = 1'b0;
  logic [2:0]          out_frame_status;
  logic [1:0]          out_frame_kind;
  logic [PosW-1:0]     out_byte_position;
  logic [ByteW-1:0]    out_echo_byte;
  logic                out_frame_end;
  logic                cfg_we      = 1'b0;
  logic [CfgIdxW-1:0]  cfg_index   = CFG_IDENT_LEN;
  logic [PosW-1:0]     cfg_wdata   = '0;

  int                  fail_count;
  int                  outstanding;
  int                  quiet_cycles = 0;
  int                  send_idle_pct = 0;
  int                  stall_pct = 0;
  int                  bytes_sent = 0;
  logic [PosW-1:0]     ident_cfg = IdentLenRst;
  logic [PosW-1:0]     data_cfg  = DataLenRst;

  crc8_checked_frame_receiver dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_rx_byte        (in_rx_byte),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_frame_status  (out_frame_status),
    .out_frame_kind    (out_frame_kind),
    .out_byte_position (out_byte_position),
    .out_echo_byte     (out_echo_byte),
    .out_frame_end     (out_frame_end),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata)
  );

  crc8_checked_frame_receiver_check frame_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_rx_byte        (in_rx_byte),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_frame_status  (out_frame_status),
    .out_frame_kind    (out_frame_kind),
    .out_byte_position (out_byte_position),
    .out_echo_byte     (out_echo_byte),
    .out_frame_end     (out_frame_end),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .fail_count        (fail_count),
    .outstanding       (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    out_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= QuietLimit) begin
      $display("crc8_checked_frame_receiver test failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_byte(input logic [ByteW-1:0] b);
    logic stalled;
    if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid   <= 1'b1;
    in_rx_byte <= b;
    forever begin
      @(negedge clk);
      stalled = in_stall;
      @(posedge clk);
      if (!stalled) break;
    end
    bytes_sent++;
  endtask

  // Hold off until every result is out, then let the pipeline settle.
  task automatic drain();
    in_valid <= 1'b0;
    forever begin
      @(negedge clk);
      if (outstanding == 0) break;
    end
    @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic program_lengths(input logic [PosW-1:0] il, input logic [PosW-1:0] dl);
    drain();
    cfg_we    <= 1'b1;
    cfg_index <= CFG_IDENT_LEN;
    cfg_wdata <= il;
    @(posedge clk);
    cfg_index <= CFG_DATA_LEN;
    cfg_wdata <= dl;
    @(posedge clk);
    cfg_we    <= 1'b0;
    ident_cfg = il;
    data_cfg  = dl;
  endtask

  // Send the first cut bytes (at most the frame length) of a frame; the frame's last byte carries the CRC.
  task automatic send_frame(input bit is_data, input bit corrupt, input int cut);
    logic [ByteW-1:0] b;
    logic [ByteW-1:0] crc;
    int               len;
    len = int'(fit_length(is_data ? data_cfg : ident_cfg));
    if (cut > len) cut = len;
    crc = 8'h00;
    for (int p = 0; p < cut; p++) begin
      if (p == 0) begin
        b = StartByte;
      end else if (p == 1) begin
        b = is_data ? TypeData : TypeIdent;
      end else if (p == len - 1) begin
        b = corrupt ? (crc ^ (8'h01 << $urandom_range(7))) : crc;
      end else begin
        b = 8'($urandom_range(255));
      end
      if (p >= 1 && p < len - 1) begin
        crc = crc8_maxim(crc, b);
      end
      send_byte(b);
    end
  endtask

  task automatic set_idling(input int mode);
    case (mode)
      0: begin send_idle_pct = 0;  stall_pct = 0;  end
      1: begin send_idle_pct = 53; stall_pct = 0;  end
      2: begin send_idle_pct = 0;  stall_pct = 53; end
      default: begin send_idle_pct = 12; stall_pct = 12; end
    endcase
  endtask

  initial begin
    int pick;
    int phase_start;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: extremes, bad start, unknown type, good and bad CRC
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(StartByte);
    send_byte(8'h00);
    send_byte(StartByte);
    send_byte(8'hFF);
    send_frame(1'b0, 1'b0, 32);
    send_frame(1'b0, 1'b1, 32);
    send_byte(8'hFF);
    send_byte(TypeIdent);
    send_byte(StartByte);
    send_byte(StartByte);

    for (int phase = 0; phase < PhaseCount; phase++) begin
      case (phase)
        0: ;
        1: program_lengths(PosW'(0), PosW'(31));
        2: program_lengths(PosW'(31), PosW'(0));
        3: program_lengths(PosW'(3), PosW'(3));
        4: program_lengths(PosW'(2), PosW'(1));
        default: program_lengths(PosW'($urandom_range(3, 12)), PosW'($urandom_range(31)));
      endcase
      set_idling(phase % 4);
      phase_start = bytes_sent;
      while (bytes_sent - phase_start < PhaseBytes) begin
        pick = $urandom_range(99);
        if (pick < 52) begin
          send_frame(1'($urandom_range(1)), 1'b0, 32);
        end else if (pick < 70) begin
          send_frame(1'($urandom_range(1)), 1'b1, 32);
        end else if (pick < 80) begin
          send_frame(1'($urandom_range(1)), 1'b0, int'($urandom_range(1, 8)));
        end else if (pick < 88) begin
          send_byte(StartByte);
          send_byte(8'($urandom_range(255)));
        end else begin
          send_byte(8'($urandom_range(255)));
        end
      end
    end

    drain();
    if (fail_count == 0) begin
      $display("crc8_checked_frame_receiver test passed");
    end else begin
      $display("crc8_checked_frame_receiver test failed");
    end
    $finish;
  end

endmodule
